FILE: hw/rtl/evwd_pkg.sv
// Shared types and constants for the event-vector word decoder.
package evwd_pkg;

    localparam int MASK_WIDTH      = 32;
    localparam int WRAP_COUNT_BITS = 30;
    localparam int IDX_W           = (MASK_WIDTH > 1) ? $clog2(MASK_WIDTH) : 1;

    localparam int TIME_HIGH_W = 28;
    localparam int TS_W        = 64;
    localparam int TS_WRAP_LSB = 34;
    localparam int TS_HIGH_LSB = 6;

    localparam logic [3:0] TYPE_CD_OFF    = 4'h0;
    localparam logic [3:0] TYPE_CD_ON     = 4'h1;
    localparam logic [3:0] TYPE_TIME_HIGH = 4'h8;
    localparam logic [3:0] TYPE_TRIGGER   = 4'hA;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    // One queued work unit: a change-detection vector or a trigger.
    typedef struct packed {
        logic                  kind;
        logic [TS_W-1:0]       ts;
        logic [10:0]           base_x;
        logic [10:0]           y;
        logic                  pol;
        logic [4:0]            chan;
        logic [MASK_WIDTH-1:0] mask;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

FILE: hw/rtl/evwd_if.sv
// Stream interfaces for raw words in and decoded results out.
interface evwd_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface

interface evwd_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [63:0] timestamp;
    logic [11:0] column;
    logic [10:0] row;
    logic        polarity;
    logic [4:0]  trigger_channel;
    logic        last_of_word;

    modport source (output valid, output result_kind, output timestamp, output column,
                     output row, output polarity, output trigger_channel,
                     output last_of_word, input ready);
    modport sink   (input valid, input result_kind, input timestamp, input column,
                     input row, input polarity, input trigger_channel,
                     input last_of_word, output ready);
endinterface

FILE: hw/rtl/evwd_front.sv
// Front end: accepts raw words, keeps the time base, queues vectors and triggers.
module evwd_front
    import evwd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    evwd_word_if.sink     words,
    input  logic          queue_full,
    output push_t         push
);

    logic [TIME_HIGH_W-1:0]     time_high_reg;
    logic [TIME_HIGH_W-1:0]     time_high_next;
    logic [WRAP_COUNT_BITS-1:0] wrap_count_reg;
    logic [WRAP_COUNT_BITS-1:0] wrap_count_next;

    logic                  accept;
    logic [3:0]            word_type;
    logic [MASK_WIDTH-1:0] mask;
    logic [TIME_HIGH_W-1:0] field;
    logic                  is_cd;

    assign words.ready = !queue_full;
    assign accept      = words.valid && words.ready;
    assign word_type   = words.raw_word[31:28];
    assign mask        = words.raw_word[32 +: MASK_WIDTH];
    assign field       = words.raw_word[TIME_HIGH_W-1:0];
    assign is_cd       = (word_type == TYPE_CD_OFF) || (word_type == TYPE_CD_ON);

    always_comb
    begin
        push.cmd.ts = (TS_W'(wrap_count_reg) << TS_WRAP_LSB)
                    | (TS_W'(time_high_reg) << TS_HIGH_LSB)
                    | TS_W'(words.raw_word[27:22]);
        push.cmd.base_x = words.raw_word[21:11];
        push.cmd.y      = words.raw_word[10:0];
        push.cmd.chan   = words.raw_word[44:40];
        if (is_cd)
        begin
            push.cmd.kind = KIND_PIXEL;
            push.cmd.pol  = word_type[0];
            push.cmd.mask = mask;
        end
        else
        begin
            // A trigger travels as a one-bit vector.
            push.cmd.kind = KIND_TRIGGER;
            push.cmd.pol  = words.raw_word[32];
            push.cmd.mask = MASK_WIDTH'(1);
        end
        push.valid = accept && ((is_cd && (mask != '0)) || (word_type == TYPE_TRIGGER));
    end

    always_comb
    begin
        time_high_next  = time_high_reg;
        wrap_count_next = wrap_count_reg;
        if (accept && (word_type == TYPE_TIME_HIGH))
        begin
            time_high_next = field;
            // Time base moved back: bump the wrap count.
            if (field < time_high_reg)
            begin
                wrap_count_next = wrap_count_reg + WRAP_COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_high_reg  <= '0;
            wrap_count_reg <= '0;
        end
        else
        begin
            time_high_reg  <= time_high_next;
            wrap_count_reg <= wrap_count_next;
        end
    end

endmodule

FILE: hw/rtl/evwd_queue.sv
// Two-entry command queue between the front end and the event emitter.
module evwd_queue
    import evwd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  full,
    output head_t head
);

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/evwd_back.sv
// Back end: walks each queued vector lowest bit first, one result per beat.
module evwd_back
    import evwd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  head_t          head,
    output logic           pop,
    evwd_result_if.source  results
);

    logic                  active_reg;
    logic                  active_next;
    cmd_t                  cur_reg;
    cmd_t                  cur_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  kind_reg;
    logic [TS_W-1:0]       ts_reg;
    logic [11:0]           column_reg;
    logic [10:0]           row_reg;
    logic                  pol_reg;
    logic [4:0]            chan_reg;
    logic                  last_reg;

    logic                  emit;
    logic                  last_bit;
    logic [MASK_WIDTH-1:0] rest_mask;
    logic [IDX_W-1:0]      idx;
    logic [11:0]           column;

    // Lowest set bit of the current mask.
    always_comb
    begin
        idx = '0;
        for (int i = MASK_WIDTH - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

    assign rest_mask = cur_reg.mask & (cur_reg.mask - MASK_WIDTH'(1));
    assign last_bit  = (rest_mask == '0);
    assign emit      = active_reg && (!out_valid_reg || results.ready);
    assign pop       = head.valid && (!active_reg || (emit && last_bit));
    assign column    = (cur_reg.kind == KIND_TRIGGER) ? 12'd0
                     : 12'(cur_reg.base_x) + 12'(idx);

    always_comb
    begin
        active_next = active_reg;
        cur_next    = cur_reg;
        if (emit)
        begin
            cur_next.mask = rest_mask;
            if (last_bit)
            begin
                active_next = 1'b0;
            end
        end
        if (pop)
        begin
            active_next = 1'b1;
            cur_next    = head.cmd;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            kind_reg   <= cur_reg.kind;
            ts_reg     <= cur_reg.ts;
            column_reg <= column;
            row_reg    <= (cur_reg.kind == KIND_TRIGGER) ? 11'd0 : cur_reg.y;
            pol_reg    <= cur_reg.pol;
            chan_reg   <= (cur_reg.kind == KIND_TRIGGER) ? cur_reg.chan : 5'd0;
            last_reg   <= last_bit;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.result_kind     = kind_reg;
    assign results.timestamp       = ts_reg;
    assign results.column          = column_reg;
    assign results.row             = row_reg;
    assign results.polarity        = pol_reg;
    assign results.trigger_channel = chan_reg;
    assign results.last_of_word    = last_reg;

endmodule

FILE: hw/rtl/event_vector_word_decoder.sv
// Event-vector word decoder top level: front end, command queue, event emitter.
//
// Usage:
//   words   - one 64-bit raw word per beat (valid/ready). Type 0/1 words carry
//             a change-detection vector, type 8 updates the time base, type 10
//             is an external trigger; every other type is dropped.
//   results - one decoded result per beat (valid/ready); last_of_word marks
//             the final result caused by a word.
//   Path: the first result of a word is registered in the queue entry, then in
//   the emitter's current command, then in the output register.
//   Throughput: the emitter produces one result per cycle while the receiver
//   is ready; the next queued word follows with no gap. Time-high and dropped
//   words produce nothing. Input acceptance is bounded by the two-entry queue
//   in front of the emitter.
//   Reset clears the time base, wrap count, queue and output register.
//   When the receiver holds ready low, the output register holds its beat, the
//   queue fills, and words.ready falls until the emitter moves again.
module event_vector_word_decoder
    import evwd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    evwd_word_if.sink     words,
    evwd_result_if.source results
);

    push_t push;
    head_t head;
    logic  queue_full;
    logic  pop;

    evwd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .queue_full (queue_full),
        .push       (push)
    );

    evwd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    evwd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

FILE: test/event_vector_word_decoder_test.sv
// Self-checking testbench for the event-vector word decoder.
`timescale 1ns / 100ps

module event_vector_word_decoder_test;
    import evwd_pkg::*;

    localparam int STUCK_LIMIT   = 2000;
    localparam int ITEM_GOAL     = 480;
    localparam int SETTLE_CYCLES = 40;
    localparam int ERROR_PRINTS  = 50;

    typedef struct packed {
        logic        drain_first;
        logic [63:0] raw;
    } word_beat_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] timestamp;
        logic [11:0] column;
        logic [10:0] row;
        logic        polarity;
        logic [4:0]  channel;
        logic        last;
    } decoded_t;

    logic clk;
    logic rst_n;

    evwd_word_if   word_bus ();
    evwd_result_if event_bus ();

    event_vector_word_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (word_bus),
        .results (event_bus)
    );

    word_beat_t                 word_backlog[$];
    decoded_t                   expected_results[$];
    logic [TIME_HIGH_W-1:0]     high_field = '0;
    logic [WRAP_COUNT_BITS-1:0] wrap_total = '0;
    int                         words_total = 0;
    int                         words_taken = 0;
    int                         error_count = 0;
    int                         stuck_cycles = 0;
    int                         send_gap = 0;
    int                         stall_left = 0;
    logic                       sender_calm = 1'b0;
    logic                       receiver_calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] make_word(input logic [31:0] mask, input logic [3:0] code,
                                              input logic [5:0] low6, input logic [10:0] x,
                                              input logic [10:0] y);
        return {mask, code, low6, x, y};
    endfunction

    function automatic logic is_decoded_type(input logic [3:0] code);
        return code == TYPE_CD_OFF || code == TYPE_CD_ON || code == TYPE_TIME_HIGH ||
               code == TYPE_TRIGGER;
    endfunction

    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 92)
            return $urandom_range(4, 8);
        else
            return $urandom_range(12, 40);
    endfunction

    task automatic push_word(input logic [63:0] raw, input logic drain_first);
        word_beat_t beat;
        beat.raw = raw;
        beat.drain_first = drain_first;
        word_backlog.push_back(beat);
        words_total++;
    endtask

    // Expand one accepted word into the results it must cause; update the time base.
    function automatic void decode_word(input logic [63:0] w);
        logic [3:0]  code;
        logic [31:0] hits;
        int          last_bit;
        decoded_t    r;
        code = w[31:28];
        r = '0;
        r.timestamp = (64'(wrap_total) << TS_WRAP_LSB) | (64'(high_field) << TS_HIGH_LSB)
                    | 64'(w[27:22]);
        if (code == TYPE_CD_OFF || code == TYPE_CD_ON)
        begin
            hits = 32'(w[32 +: MASK_WIDTH]);
            last_bit = -1;
            for (int b = 0; b < 32; b++)
                if (hits[b])
                    last_bit = b;
            for (int b = 0; b < 32; b++)
            begin
                if (hits[b])
                begin
                    r.kind = KIND_PIXEL;
                    r.column = 12'(w[21:11]) + 12'(b);
                    r.row = w[10:0];
                    r.polarity = code[0];
                    r.channel = '0;
                    r.last = (b == last_bit);
                    expected_results.push_back(r);
                end
            end
        end
        else if (code == TYPE_TIME_HIGH)
        begin
            // a backward move of the time base counts one wrap
            if (w[TIME_HIGH_W-1:0] < high_field)
                wrap_total = wrap_total + WRAP_COUNT_BITS'(1);
            high_field = w[TIME_HIGH_W-1:0];
        end
        else if (code == TYPE_TRIGGER)
        begin
            r.kind = KIND_TRIGGER;
            r.polarity = w[32];
            r.channel = w[44:40];
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endfunction

    task automatic flag_error(input string what);
        if (error_count < ERROR_PRINTS)
            $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h, want %h", name, got, want));
    endtask

    task automatic check_result();
        decoded_t want;
        if (expected_results.size() == 0)
            flag_error($sformatf("result with nothing pending, ts %h", event_bus.timestamp));
        else
        begin
            want = expected_results.pop_front();
            compare_field("result_kind", 64'(event_bus.result_kind), 64'(want.kind));
            compare_field("timestamp", event_bus.timestamp, want.timestamp);
            compare_field("column", 64'(event_bus.column), 64'(want.column));
            compare_field("row", 64'(event_bus.row), 64'(want.row));
            compare_field("polarity", 64'(event_bus.polarity), 64'(want.polarity));
            compare_field("trigger_channel", 64'(event_bus.trigger_channel),
                          64'(want.channel));
            compare_field("last_of_word", 64'(event_bus.last_of_word), 64'(want.last));
        end
    endtask

    // Word driver: hold a beat until taken, then idle or load the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bus.valid <= 1'b0;
            word_bus.raw_word <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (word_bus.valid && word_bus.ready)
            begin
                decode_word(word_bus.raw_word);
                words_taken++;
                if ($urandom_range(0, 63) == 0)
                    sender_calm <= !sender_calm;
            end
            if (!word_bus.valid || word_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    word_bus.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (word_backlog.size() != 0 &&
                         (!word_backlog[0].drain_first || expected_results.size() == 0))
                begin
                    word_bus.valid <= 1'b1;
                    word_bus.raw_word <= word_backlog[0].raw;
                    void'(word_backlog.pop_front());
                    send_gap <= (!sender_calm && $urandom_range(0, 99) < 35) ? idle_span() : 0;
                end
                else
                    word_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each beat, stall ready in random stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_bus.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (event_bus.valid && event_bus.ready)
            begin
                check_result();
                if ($urandom_range(0, 63) == 0)
                    receiver_calm <= !receiver_calm;
            end
            if (stall_left > 0)
            begin
                event_bus.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                event_bus.ready <= 1'b1;
                if (!receiver_calm && $urandom_range(0, 99) < 20)
                    stall_left <= idle_span();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_bus.valid && word_bus.ready) || (event_bus.valid && event_bus.ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("FAIL event_vector_word_decoder");
        $finish;
    end

    initial
    begin
        logic [31:0]            mask;
        logic [3:0]             code;
        logic [TIME_HIGH_W-1:0] stim_high;
        int                     pick;
        int                     useful;

        rst_n = 1'b0;

        // directed: field extremes, empty vector, time base moves, triggers
        push_word(make_word('1, TYPE_CD_ON, '1, '1, '1), 1'b0);
        push_word(make_word(32'h0000_0001, TYPE_CD_OFF, '0, '0, '0), 1'b0);
        push_word(make_word(32'h8000_0000, TYPE_CD_ON, 6'd9, 11'd5, 11'd100), 1'b0);
        push_word(make_word('0, TYPE_CD_OFF, 6'd33, 11'd3, 11'd7), 1'b0);
        push_word(make_word('1, TYPE_TIME_HIGH, '1, '1, '1), 1'b0);
        push_word(make_word('1, TYPE_TRIGGER, 6'd17, '1, '1), 1'b0);
        push_word(make_word(32'h5555_5555, TYPE_CD_ON, 6'd1, 11'd1000, 11'd2000), 1'b0);
        push_word(make_word('0, TYPE_TIME_HIGH, '1, '1, '1), 1'b0);
        push_word(make_word(32'hAAAA_AAAA, TYPE_TIME_HIGH, '0, '0, '0), 1'b0);
        push_word(make_word(32'hFFFF_E0FE, TYPE_TRIGGER, '0, '0, '0), 1'b0);
        push_word(make_word({19'd0, 5'h15, 7'd0, 1'b1}, TYPE_TRIGGER, 6'd42, 11'd9, 11'd9),
                  1'b0);
        for (int t = 0; t < 16; t++)
            if (!is_decoded_type(4'(t)))
                push_word(make_word('1, 4'(t), '1, '1, '1), 1'b0);
        push_word(make_word('0, TYPE_TIME_HIGH, '0, '0, 11'd5), 1'b0);
        push_word(make_word(32'h8000_0001, TYPE_CD_OFF, '1, '1, '0), 1'b0);

        // random: mostly decoded types, with some noise words mixed in
        stim_high = 28'd5;
        useful = 0;
        while (words_total < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                code = $urandom_range(0, 1) ? TYPE_CD_ON : TYPE_CD_OFF;
                case ($urandom_range(0, 9))
                    0:       mask = '0;
                    1:       mask = '1;
                    2, 3, 4: mask = 32'd1 << $urandom_range(0, 31);
                    5, 6:    mask = $urandom & $urandom & $urandom;
                    default: mask = $urandom;
                endcase
                push_word(make_word(mask, code, 6'($urandom), 11'($urandom), 11'($urandom)),
                          useful == ITEM_GOAL / 2);
                useful++;
            end
            else if (pick < 70)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    stim_high = stim_high + TIME_HIGH_W'($urandom_range(0, 3000));
                else if (pick < 85)
                    stim_high = TIME_HIGH_W'($urandom_range(0, 32'(stim_high)));
                else
                    stim_high = TIME_HIGH_W'($urandom);
                push_word({32'($urandom), TYPE_TIME_HIGH, stim_high}, useful == ITEM_GOAL / 2);
                useful++;
            end
            else if (pick < 88)
            begin
                push_word(make_word($urandom, TYPE_TRIGGER, 6'($urandom), 11'($urandom),
                                    11'($urandom)), useful == ITEM_GOAL / 2);
                useful++;
            end
            else
            begin
                do
                    code = 4'($urandom);
                while (is_decoded_type(code));
                push_word(make_word($urandom, code, 6'($urandom), 11'($urandom),
                                    11'($urandom)), 1'b0);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken < words_total || expected_results.size() != 0)
            @(posedge clk);
        // give stray beats time to show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS event_vector_word_decoder");
        else
            $display("FAIL event_vector_word_decoder");
        $finish;
    end

endmodule
